FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a condition at the same edge.
`define ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// Check that a trigger implies a condition at the next edge.
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/core/wce_pkg.sv
// ----------------------------------------------------------------------------
// wce_pkg
// Shared widths, register indexes, sequencer states and control types.
// ----------------------------------------------------------------------------
package wce_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 16;
    localparam int FRAC_W   = 12;
    localparam int SPP_W    = 13;
    localparam int CNT_W    = 13;
    localparam int SUM_W    = 28;
    localparam int COL_W    = 20;
    localparam int MEANP_W  = 15;
    localparam int MEANN_W  = 16;
    localparam int QUO_W    = 16;
    localparam int DATA_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_SAMPLES_PER_COLUMN = 4096;

    localparam int STEP_COUNT = 16;
    localparam int STEP_W     = $clog2(STEP_COUNT);

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_SCALE   = 2'd1;

    localparam logic [SPP_W-1:0] SPP_RESET   = 13'd1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } step_ctrl_t;

endpackage

FILE: rtl/core/wce_scaler.sv
// ----------------------------------------------------------------------------
// wce_scaler
// Bit-serial signed by unsigned multiplier with Q4.12 shift and saturation.
// ----------------------------------------------------------------------------
module wce_scaler
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wce_pkg::step_ctrl_t                   ctrl,
    input  logic signed [wce_pkg::SAMPLE_W-1:0]   sample_value,
    input  logic        [wce_pkg::SCALE_W-1:0]    amplitude_scale,
    output logic signed [wce_pkg::SAMPLE_W-1:0]   scaled
);

    localparam int HI_W   = wce_pkg::SAMPLE_W + 1;
    localparam int PROD_W = wce_pkg::SAMPLE_W + wce_pkg::SCALE_W;
    localparam int Q_W    = PROD_W - wce_pkg::FRAC_W;

    logic signed [wce_pkg::SAMPLE_W-1:0] mcand_reg;
    logic signed [HI_W-1:0]              hi_reg;
    logic signed [HI_W-1:0]              hi_next;
    logic [wce_pkg::SCALE_W-1:0]         lo_reg;
    logic [wce_pkg::SCALE_W-1:0]         lo_next;
    logic signed [HI_W-1:0]              addend;
    logic signed [HI_W-1:0]              psum;
    logic [PROD_W-1:0]                   product;
    logic [Q_W-1:0]                      q;
    logic                                fits;

    always_comb
    begin
        addend  = lo_reg[0] ? HI_W'(mcand_reg) : '0;
        psum    = hi_reg + addend;
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (ctrl.load)
        begin
            hi_next = '0;
            lo_next = amplitude_scale;
        end
        else if (ctrl.step)
        begin
            hi_next = {psum[HI_W-1], psum[HI_W-1:1]};
            lo_next = {psum[0], lo_reg[wce_pkg::SCALE_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mcand_reg <= sample_value;
        end
    end

    always_comb
    begin
        product = {hi_reg[wce_pkg::SAMPLE_W-1:0], lo_reg};
        q       = product[PROD_W-1:wce_pkg::FRAC_W];
        fits    = (q[Q_W-1:wce_pkg::SAMPLE_W-1] == '0) || (q[Q_W-1:wce_pkg::SAMPLE_W-1] == '1);
        if (fits)
        begin
            scaled = q[wce_pkg::SAMPLE_W-1:0];
        end
        else if (q[Q_W-1])
        begin
            scaled = {1'b1, {(wce_pkg::SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            scaled = {1'b0, {(wce_pkg::SAMPLE_W-1){1'b1}}};
        end
    end

endmodule

FILE: rtl/core/wce_divider.sv
// ----------------------------------------------------------------------------
// wce_divider
// Restoring divider, one quotient bit per step, for column means.
// ----------------------------------------------------------------------------
module wce_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wce_pkg::step_ctrl_t           ctrl,
    input  logic [wce_pkg::SUM_W-1:0]     dividend,
    input  logic [wce_pkg::CNT_W-1:0]     divisor,
    output logic [wce_pkg::QUO_W-1:0]     quotient
);

    localparam int TRY_W  = wce_pkg::CNT_W + 1;

    logic [wce_pkg::CNT_W-1:0] rem_reg;
    logic [wce_pkg::CNT_W-1:0] rem_next;
    logic [wce_pkg::QUO_W-1:0] quo_reg;
    logic [wce_pkg::QUO_W-1:0] quo_next;
    logic [wce_pkg::CNT_W-1:0] div_reg;
    logic [TRY_W-1:0]          trial;
    logic [TRY_W-1:0]          diff;
    logic                      ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[wce_pkg::QUO_W-1]};
        ge       = trial >= {1'b0, div_reg};
        diff     = trial - {1'b0, div_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctrl.load)
        begin
            rem_next = wce_pkg::CNT_W'(dividend[wce_pkg::SUM_W-1:wce_pkg::QUO_W]);
            quo_next = dividend[wce_pkg::QUO_W-1:0];
        end
        else if (ctrl.step)
        begin
            rem_next = ge ? diff[wce_pkg::CNT_W-1:0] : trial[wce_pkg::CNT_W-1:0];
            quo_next = {quo_reg[wce_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            div_reg <= divisor;
        end
    end

    assign quotient = quo_reg;

endmodule

FILE: rtl/core/waveform_column_envelope.sv
// ----------------------------------------------------------------------------
// waveform_column_envelope
// Per-channel mean positive / mean negative envelope of a waveform column.
//
// Input requests (in_valid/in_ready) carry a channel and a Q1.15 sample.
// in_ready is high only while the sequencer is idle; one sample is in work
// at a time. The sample goes through a bit-serial multiplier, an accumulate
// step, and, when the column closes, two restoring dividers that run side
// by side. A sample that closes no column frees in_ready once it has been
// accumulated; a sample that closes a column raises out_valid and in_ready
// together once the dividers are done and the output register is free.
// Result requests (out_valid/out_ready) come from an output register; the
// next sample is accepted while a result still waits there. If the receiver
// stalls, the sequencer holds only when a second result is ready to load.
// Configuration requests (cfg_valid/cfg_ready) are always taken; index 0 is
// samples_per_pixel, index 1 is amplitude_scale, others are dropped.
// Reset clears all accumulators and column indices, sets samples_per_pixel
// to 1 and amplitude_scale to 1.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waveform_column_envelope
#(
    parameter int CHANNEL_COUNT = 2
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  channel,
    input  logic signed [wce_pkg::SAMPLE_W-1:0]   sample_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_channel,
    output logic [wce_pkg::COL_W-1:0]             column,
    output logic [wce_pkg::MEANP_W-1:0]           mean_positive,
    output logic [wce_pkg::MEANN_W-1:0]           mean_negative,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wce_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wce_pkg::DATA_W-1:0]            cfg_data
);

    localparam int MAG_W   = wce_pkg::SAMPLE_W + 1;
    localparam int TOTAL_W = wce_pkg::CNT_W + 1;
    localparam logic [wce_pkg::STEP_W-1:0] STEP_LAST = wce_pkg::STEP_W'(wce_pkg::STEP_COUNT - 1);
    localparam logic [wce_pkg::SPP_W-1:0] SPP_MAX =
        wce_pkg::SPP_W'(wce_pkg::MAX_SAMPLES_PER_COLUMN);

    wce_pkg::state_t state_reg;
    wce_pkg::state_t state_next;

    logic [wce_pkg::STEP_W-1:0] step_reg;
    logic [wce_pkg::STEP_W-1:0] step_next;

    logic [wce_pkg::SPP_W-1:0]   spp_reg;
    logic [wce_pkg::SCALE_W-1:0] scale_reg;

    logic [wce_pkg::SUM_W-1:0] pos_sum_reg   [CHANNEL_COUNT];
    logic [wce_pkg::SUM_W-1:0] neg_sum_reg   [CHANNEL_COUNT];
    logic [wce_pkg::CNT_W-1:0] pos_count_reg [CHANNEL_COUNT];
    logic [wce_pkg::CNT_W-1:0] neg_count_reg [CHANNEL_COUNT];
    logic [wce_pkg::COL_W-1:0] col_reg       [CHANNEL_COUNT];

    logic                      ch_reg;
    logic [wce_pkg::COL_W-1:0] col_hold_reg;
    logic                      pos_any_reg;
    logic                      neg_any_reg;

    logic                        out_valid_reg;
    logic                        out_channel_reg;
    logic [wce_pkg::COL_W-1:0]   column_reg;
    logic [wce_pkg::MEANP_W-1:0] mean_positive_reg;
    logic [wce_pkg::MEANN_W-1:0] mean_negative_reg;

    logic accept;
    logic channel_ok;
    logic emit_load;
    logic out_free;
    logic accum_en;

    wce_pkg::step_ctrl_t scale_ctrl;
    wce_pkg::step_ctrl_t div_ctrl;

    logic signed [wce_pkg::SAMPLE_W-1:0] scaled;
    logic                      is_neg;
    logic [MAG_W-1:0]          mag;
    logic [wce_pkg::SUM_W-1:0] pos_sum_new;
    logic [wce_pkg::SUM_W-1:0] neg_sum_new;
    logic [wce_pkg::CNT_W-1:0] pos_count_new;
    logic [wce_pkg::CNT_W-1:0] neg_count_new;
    logic [TOTAL_W-1:0]        total;
    logic [wce_pkg::SPP_W-1:0] spp_eff;
    logic                      close;

    logic [wce_pkg::QUO_W-1:0] pos_quo;
    logic [wce_pkg::QUO_W-1:0] neg_quo;
    logic [TOTAL_W-1:0]        total0;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg   <= wce_pkg::SPP_RESET;
            scale_reg <= wce_pkg::SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wce_pkg::CFG_SAMPLES_PER_PIXEL: spp_reg   <= cfg_data[wce_pkg::SPP_W-1:0];
                wce_pkg::CFG_AMPLITUDE_SCALE:   scale_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    assign accept     = in_valid && in_ready;
    assign channel_ok = int'(channel) < CHANNEL_COUNT;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wce_pkg::ST_IDLE:
            begin
                if (accept && channel_ok)
                begin
                    state_next = wce_pkg::ST_SCALE;
                end
            end
            wce_pkg::ST_SCALE:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = wce_pkg::ST_ACCUM;
                end
            end
            wce_pkg::ST_ACCUM:
            begin
                state_next = close ? wce_pkg::ST_DIVIDE : wce_pkg::ST_IDLE;
            end
            wce_pkg::ST_DIVIDE:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = wce_pkg::ST_EMIT;
                end
            end
            wce_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = wce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wce_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        scale_ctrl      = '0;
        div_ctrl        = '0;
        accum_en        = 1'b0;
        emit_load       = 1'b0;
        step_next       = '0;
        case (state_reg)
            wce_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                scale_ctrl.load = accept;
            end
            wce_pkg::ST_SCALE:
            begin
                scale_ctrl.step = 1'b1;
                step_next       = step_reg + 1'b1;
            end
            wce_pkg::ST_ACCUM:
            begin
                accum_en      = 1'b1;
                div_ctrl.load = close;
            end
            wce_pkg::ST_DIVIDE:
            begin
                div_ctrl.step = 1'b1;
                step_next     = step_reg + 1'b1;
            end
            wce_pkg::ST_EMIT:
            begin
                emit_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wce_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= channel;
        end
    end

    // ------------------------------------------------------------------------
    // Scaling
    // ------------------------------------------------------------------------
    wce_scaler u_scaler
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (scale_ctrl),
        .sample_value    (sample_value),
        .amplitude_scale (scale_reg),
        .scaled          (scaled)
    );

    // ------------------------------------------------------------------------
    // Accumulation
    // ------------------------------------------------------------------------
    always_comb
    begin
        is_neg        = scaled[wce_pkg::SAMPLE_W-1];
        mag           = is_neg ? (MAG_W'(0) - MAG_W'(scaled)) : MAG_W'(scaled);
        pos_sum_new   = pos_sum_reg[ch_reg];
        neg_sum_new   = neg_sum_reg[ch_reg];
        pos_count_new = pos_count_reg[ch_reg];
        neg_count_new = neg_count_reg[ch_reg];
        if (is_neg)
        begin
            neg_sum_new   = neg_sum_new + wce_pkg::SUM_W'(mag);
            neg_count_new = neg_count_new + 1'b1;
        end
        else
        begin
            pos_sum_new   = pos_sum_new + wce_pkg::SUM_W'(mag);
            pos_count_new = pos_count_new + 1'b1;
        end
        total = TOTAL_W'(pos_count_new) + TOTAL_W'(neg_count_new);
        if (spp_reg == '0)
        begin
            spp_eff = wce_pkg::SPP_W'(1);
        end
        else if (spp_reg > SPP_MAX)
        begin
            spp_eff = SPP_MAX;
        end
        else
        begin
            spp_eff = spp_reg;
        end
        close = total >= TOTAL_W'(spp_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                pos_sum_reg[c]   <= '0;
                neg_sum_reg[c]   <= '0;
                pos_count_reg[c] <= '0;
                neg_count_reg[c] <= '0;
                col_reg[c]       <= '0;
            end
        end
        else if (accum_en)
        begin
            if (close)
            begin
                pos_sum_reg[ch_reg]   <= '0;
                neg_sum_reg[ch_reg]   <= '0;
                pos_count_reg[ch_reg] <= '0;
                neg_count_reg[ch_reg] <= '0;
                col_reg[ch_reg]       <= col_reg[ch_reg] + 1'b1;
            end
            else
            begin
                pos_sum_reg[ch_reg]   <= pos_sum_new;
                neg_sum_reg[ch_reg]   <= neg_sum_new;
                pos_count_reg[ch_reg] <= pos_count_new;
                neg_count_reg[ch_reg] <= neg_count_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ctrl.load)
        begin
            col_hold_reg <= col_reg[ch_reg];
            pos_any_reg  <= pos_count_new != '0;
            neg_any_reg  <= neg_count_new != '0;
        end
    end

    // ------------------------------------------------------------------------
    // Means
    // ------------------------------------------------------------------------
    wce_divider u_div_pos
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (pos_sum_new),
        .divisor  (pos_count_new),
        .quotient (pos_quo)
    );

    wce_divider u_div_neg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (neg_sum_new),
        .divisor  (neg_count_new),
        .quotient (neg_quo)
    );

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_channel_reg   <= ch_reg;
            column_reg        <= col_hold_reg;
            mean_positive_reg <= pos_any_reg ? pos_quo[wce_pkg::MEANP_W-1:0] : '0;
            mean_negative_reg <= neg_any_reg ? neg_quo : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign column        = column_reg;
    assign mean_positive = mean_positive_reg;
    assign mean_negative = mean_negative_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    assign total0 = TOTAL_W'(pos_count_reg[0]) + TOTAL_W'(neg_count_reg[0]);

    `ASSERT_NEXT(a_accept_starts_scale, accept && channel_ok, state_reg == wce_pkg::ST_SCALE, "accepted sample did not start scaling")
    `ASSERT_NEXT(a_scale_ends_accum, (state_reg == wce_pkg::ST_SCALE) && (step_reg == STEP_LAST), state_reg == wce_pkg::ST_ACCUM, "scaling did not end in accumulate")
    `ASSERT_NEXT(a_emit_sets_valid, emit_load, out_valid_reg, "loaded result not presented")
    `ASSERT_SAME(a_mean_neg_range, out_valid_reg, mean_negative_reg <= 16'h8000, "negative mean out of range")
    `ASSERT_ALWAYS(a_column_count_bound, total0 < TOTAL_W'(wce_pkg::MAX_SAMPLES_PER_COLUMN), "open column holds too many samples")

endmodule

FILE: verif/waveform_column_envelope_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_column_envelope_test
// Self-checking bench for the per-channel column envelope block. Audio
// samples go in through the request channel, and a scoreboard rebuilds each
// column's mean positive level and mean negative magnitude from the same
// gain and column length. Directed samples cover gain saturation, floor
// rounding, zero as a positive value, column length clamping, a column
// length lowered mid-column and a long receiver hold-off that backs the
// block up into its input; random phases then vary both registers, the
// sample mix and the idle patterns on both sides.
// ----------------------------------------------------------------------------
module waveform_column_envelope_test;

    localparam logic [wce_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [wce_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_OFF_CYCLES = 300;

    class column_tracker;
        typedef struct {
            bit                          ch;
            bit [wce_pkg::COL_W-1:0]     col;
            bit [wce_pkg::MEANP_W-1:0]   mean_pos;
            bit [wce_pkg::MEANN_W-1:0]   mean_neg;
        } column_t;

        bit [wce_pkg::SPP_W-1:0]   spp_reg;
        bit [wce_pkg::SCALE_W-1:0] gain_reg;
        bit [wce_pkg::SUM_W-1:0]   pos_sum [2];
        bit [wce_pkg::SUM_W-1:0]   neg_sum [2];
        bit [wce_pkg::CNT_W-1:0]   pos_cnt [2];
        bit [wce_pkg::CNT_W-1:0]   neg_cnt [2];
        bit [wce_pkg::COL_W-1:0]   col_idx [2];
        column_t                   pending_columns [$];
        int unsigned               failures;

        function new();
            spp_reg = wce_pkg::SPP_RESET;
            gain_reg = wce_pkg::SCALE_RESET;
            for (int c = 0; c < 2; c++)
            begin
                pos_sum[c] = '0;
                neg_sum[c] = '0;
                pos_cnt[c] = '0;
                neg_cnt[c] = '0;
                col_idx[c] = '0;
            end
            failures = 0;
        endfunction

        function void write_reg(logic [wce_pkg::CFG_IDX_W-1:0] idx,
                                logic [wce_pkg::DATA_W-1:0] data);
            case (idx)
                wce_pkg::CFG_SAMPLES_PER_PIXEL: spp_reg = data[wce_pkg::SPP_W-1:0];
                wce_pkg::CFG_AMPLITUDE_SCALE:   gain_reg = data;
                default: ;
            endcase
        endfunction

        function int apply_gain(logic signed [wce_pkg::SAMPLE_W-1:0] s);
            longint prod;
            prod = longint'(s) * longint'(gain_reg);
            prod = prod >>> wce_pkg::FRAC_W;
            if (prod > 32767)
                prod = 32767;
            if (prod < -32768)
                prod = -32768;
            return int'(prod);
        endfunction

        function void take_sample(bit ch, logic signed [wce_pkg::SAMPLE_W-1:0] s);
            int v;
            int unsigned total;
            int unsigned len;
            column_t c;
            v = apply_gain(s);
            if (v < 0)
            begin
                neg_sum[ch] = neg_sum[ch] + wce_pkg::SUM_W'(-v);
                neg_cnt[ch] = neg_cnt[ch] + 1'b1;
            end
            else
            begin
                pos_sum[ch] = pos_sum[ch] + wce_pkg::SUM_W'(v);
                pos_cnt[ch] = pos_cnt[ch] + 1'b1;
            end
            total = int'(pos_cnt[ch]) + int'(neg_cnt[ch]);
            len = (spp_reg == 0) ? 1 :
                  (spp_reg > wce_pkg::MAX_SAMPLES_PER_COLUMN) ?
                  wce_pkg::MAX_SAMPLES_PER_COLUMN : spp_reg;
            if (total < len)
                return;
            c.ch = ch;
            c.col = col_idx[ch];
            c.mean_pos = (pos_cnt[ch] != 0) ?
                         wce_pkg::MEANP_W'(pos_sum[ch] / pos_cnt[ch]) : '0;
            c.mean_neg = (neg_cnt[ch] != 0) ?
                         wce_pkg::MEANN_W'(neg_sum[ch] / neg_cnt[ch]) : '0;
            pending_columns.push_back(c);
            pos_sum[ch] = '0;
            neg_sum[ch] = '0;
            pos_cnt[ch] = '0;
            neg_cnt[ch] = '0;
            col_idx[ch] = col_idx[ch] + 1'b1;
        endfunction

        function void match_column(logic ch, logic [wce_pkg::COL_W-1:0] col,
                                   logic [wce_pkg::MEANP_W-1:0] mp,
                                   logic [wce_pkg::MEANN_W-1:0] mn);
            column_t e;
            if (pending_columns.size() == 0)
            begin
                $error("out_channel %0d column %0d: result with none pending", ch, col);
                failures++;
                return;
            end
            e = pending_columns.pop_front();
            if (ch !== e.ch)
            begin
                $error("out_channel: expected %0d, got %0d", e.ch, ch);
                failures++;
            end
            if (col !== e.col)
            begin
                $error("column: expected %0d, got %0d", e.col, col);
                failures++;
            end
            if (mp !== e.mean_pos)
            begin
                $error("mean_positive: expected %0d, got %0d", e.mean_pos, mp);
                failures++;
            end
            if (mn !== e.mean_neg)
            begin
                $error("mean_negative: expected %0d, got %0d", e.mean_neg, mn);
                failures++;
            end
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 channel;
    logic signed [wce_pkg::SAMPLE_W-1:0]  sample_value;
    logic                                 out_valid;
    logic                                 out_ready;
    logic                                 out_channel;
    logic [wce_pkg::COL_W-1:0]            column;
    logic [wce_pkg::MEANP_W-1:0]          mean_positive;
    logic [wce_pkg::MEANN_W-1:0]          mean_negative;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [wce_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [wce_pkg::DATA_W-1:0]           cfg_data;

    column_tracker tracker;
    int            hold_request;
    bit            burst_mode;

    waveform_column_envelope i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .channel       (channel),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_channel   (out_channel),
        .column        (column),
        .mean_positive (mean_positive),
        .mean_negative (mean_negative),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_column(out_channel, column, mean_positive, mean_negative);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode)
            return 0;
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic logic signed [wce_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            4: return 16'sd1;
            5: return wce_pkg::SAMPLE_W'($urandom_range(0, 255)) - 16'sd128;
            default: return wce_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Receiver: random ready runs and stalls, plus a long hold-off on request.
    initial
    begin
        int ready_run;
        int stall_run;
        ready_run = 0;
        stall_run = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            else if (ready_run != 0)
            begin
                out_ready <= 1'b1;
                ready_run--;
            end
            else if (stall_run != 0)
            begin
                out_ready <= 1'b0;
                stall_run--;
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    ready_run = $urandom_range(1, 24);
                else if ($urandom_range(0, 9) < 8)
                    stall_run = $urandom_range(1, 4);
                else
                    stall_run = $urandom_range(20, 80);
                out_ready <= (ready_run != 0);
            end
        end
    end

    task automatic send_sample(bit ch, logic signed [wce_pkg::SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        in_valid <= 1'b1;
        channel <= ch;
        sample_value <= s;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_sample(ch, s);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop the request, wait out every pending column, then let the block settle.
    task automatic drain_columns();
        in_valid <= 1'b0;
        while (tracker.pending_columns.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_reg(logic [wce_pkg::CFG_IDX_W-1:0] idx,
                               logic [wce_pkg::DATA_W-1:0] data);
        drain_columns();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int n_items;
        tracker = new();
        hold_request = 0;
        burst_mode = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        channel = 1'b0;
        sample_value = '0;
        cfg_valid = 1'b0;
        cfg_index = wce_pkg::CFG_SAMPLES_PER_PIXEL;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Unity gain, one sample per column.
        send_sample(1'b0, 16'sh7FFF);
        send_sample(1'b1, 16'sh8000);
        send_sample(1'b0, 16'sh0000);
        send_sample(1'b1, -16'sd1);
        send_sample(1'b0, 16'sd1);
        send_sample(1'b1, 16'sh5555);
        send_sample(1'b0, 16'shAAAA);

        // Full gain: saturation both ways, floor on negative products.
        program_reg(wce_pkg::CFG_AMPLITUDE_SCALE, 16'hFFFF);
        send_sample(1'b0, 16'sh7FFF);
        send_sample(1'b1, 16'sh8000);
        send_sample(1'b0, -16'sd1);
        send_sample(1'b1, 16'sd1);

        // Zero gain turns every sample into a non-negative zero.
        program_reg(wce_pkg::CFG_AMPLITUDE_SCALE, 16'h0000);
        send_sample(1'b0, 16'sh8000);
        send_sample(1'b1, 16'sh7FFF);

        // Smallest gain: tiny negatives still floor to -1.
        program_reg(wce_pkg::CFG_AMPLITUDE_SCALE, 16'h0001);
        send_sample(1'b0, -16'sd1);
        send_sample(1'b1, 16'sd1);
        send_sample(1'b0, 16'sh8000);

        // Zero column length acts as one; spare indexes are dropped.
        program_reg(wce_pkg::CFG_AMPLITUDE_SCALE, 16'h1000);
        program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'h0000);
        program_reg(CFG_SPARE_A, 16'hFFFF);
        program_reg(CFG_SPARE_B, 16'h0003);
        send_sample(1'b0, 16'sd100);
        send_sample(1'b1, -16'sd100);

        // Mixed column, then a column with no negatives.
        program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'd3);
        send_sample(1'b0, -16'sd5);
        send_sample(1'b0, 16'sd7);
        send_sample(1'b0, 16'sd8);
        send_sample(1'b1, 16'sd9);
        send_sample(1'b1, 16'sd0);
        send_sample(1'b1, 16'sd4);

        // Column length lowered mid-column closes the open columns.
        program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'd4096);
        for (int i = 0; i < 40; i++)
            send_sample(i % 4 == 0, pick_sample());
        program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'd5);
        send_sample(1'b0, pick_sample());
        send_sample(1'b1, pick_sample());

        // Receiver holds off while samples keep coming.
        program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'd1);
        hold_request = HOLD_OFF_CYCLES;
        burst_mode = 1'b1;
        for (int i = 0; i < 60; i++)
            send_sample(1'($urandom), pick_sample());
        burst_mode = 1'b0;

        // Column length above the maximum keeps the columns open.
        program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'hFFFF);
        burst_mode = 1'b1;
        for (int i = 0; i < 40; i++)
            send_sample(1'($urandom), pick_sample());
        burst_mode = 1'b0;

        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 7))
                0: program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'd0);
                1: program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'd1);
                2: program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'd2);
                3: program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL, 16'd3);
                4: program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL,
                               wce_pkg::DATA_W'($urandom_range(4, 16)));
                5: program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL,
                               wce_pkg::DATA_W'($urandom_range(17, 64)));
                6: program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL,
                               wce_pkg::DATA_W'($urandom_range(1, 8)));
                default: program_reg(wce_pkg::CFG_SAMPLES_PER_PIXEL,
                                     wce_pkg::DATA_W'($urandom));
            endcase
            case ($urandom_range(0, 5))
                0: program_reg(wce_pkg::CFG_AMPLITUDE_SCALE, 16'h1000);
                1: program_reg(wce_pkg::CFG_AMPLITUDE_SCALE, 16'h0000);
                2: program_reg(wce_pkg::CFG_AMPLITUDE_SCALE, 16'hFFFF);
                3: program_reg(wce_pkg::CFG_AMPLITUDE_SCALE,
                               wce_pkg::DATA_W'($urandom_range(2048, 8192)));
                4: program_reg(wce_pkg::CFG_AMPLITUDE_SCALE, wce_pkg::DATA_W'($urandom));
                default: program_reg(wce_pkg::CFG_AMPLITUDE_SCALE,
                                     wce_pkg::DATA_W'($urandom_range(1, 255)));
            endcase
            if ($urandom_range(0, 3) == 0)
                program_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                            wce_pkg::DATA_W'($urandom));
            burst_mode = (ph % 4 == 3);
            n_items = $urandom_range(70, 110);
            for (int i = 0; i < n_items; i++)
                send_sample(1'($urandom), pick_sample());
            burst_mode = 1'b0;
        end

        drain_columns();
        if (tracker.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
